// ===== hdl/bts_pkg.sv =====
// Shared types, constants and address/wrap helpers for the bilinear texture sampler.
package bts_pkg;

    localparam int MAX_SIDE   = 256;
    localparam int SIDE_BITS  = 8;
    localparam int TEX_DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W     = 2 * SIDE_BITS;
    localparam int CHANNELS   = 4;
    localparam int TEXEL_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 24;
    localparam int OFFS_BITS  = 8;
    localparam int SIZE_W     = 9;
    localparam int MOD_W      = SIZE_W + 1;
    localparam int REM_W      = SIZE_W;
    localparam int PROD_W     = 35;
    localparam int IDX_W      = PROD_W - FRAC_BITS;
    localparam int MAG_W      = 18;
    localparam int MOD_STEP   = 3;
    localparam int MOD_STAGES = MAG_W / MOD_STEP;
    localparam int HP_W       = TEXEL_BITS + FRAC_BITS + 1;
    localparam int ACC_W      = HP_W + FRAC_BITS + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic signed [PROD_W-1:0] ONE_Q  = PROD_W'(1) <<< FRAC_BITS;
    localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic [FRAC_BITS:0]       ONE_F  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [ACC_W-1:0]         RND_Q  = ACC_W'(1) << (2 * FRAC_BITS - 1);

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_WIDTH  = 3'd0,
        CFG_TEX_HEIGHT = 3'd1,
        CFG_OFFSET_X   = 3'd2,
        CFG_OFFSET_Y   = 3'd3,
        CFG_WRAP_X     = 3'd4,
        CFG_WRAP_Y     = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        WRAP_CLAMP  = 2'd0,
        WRAP_REPEAT = 2'd1,
        WRAP_MIRROR = 2'd2
    } wrap_t;

    typedef logic [TEXEL_BITS-1:0] texel_t;
    typedef texel_t [CHANNELS-1:0] pixel_t;

    typedef struct packed {
        logic                         action;
        logic [SIDE_BITS-1:0]         texel_x;
        logic [SIDE_BITS-1:0]         texel_y;
        logic [TEXEL_BITS-1:0]        texel_c0;
        logic [TEXEL_BITS-1:0]        texel_c1;
        logic [TEXEL_BITS-1:0]        texel_c2;
        logic [TEXEL_BITS-1:0]        texel_c3;
        logic signed [COORD_BITS-1:0] u_coord;
        logic signed [COORD_BITS-1:0] v_coord;
    } req_t;

    typedef struct packed {
        logic [TEXEL_BITS-1:0] sample_c0;
        logic [TEXEL_BITS-1:0] sample_c1;
        logic [TEXEL_BITS-1:0] sample_c2;
        logic [TEXEL_BITS-1:0] sample_c3;
    } rsp_t;

    // One axis on its way through the remainder stages
    typedef struct packed {
        logic signed [IDX_W-1:0] idx;
        logic [FRAC_BITS-1:0]    frac;
        logic                    neg;
        logic [MAG_W-1:0]        mag;
        logic [REM_W-1:0]        rem;
    } axis_t;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] waddr;
        pixel_t            wdata;
        axis_t             ax;
        axis_t             ay;
    } front_t;

    typedef struct packed {
        logic [SIDE_BITS-1:0] c0;
        logic [SIDE_BITS-1:0] c1;
    } coord_pair_t;

    // Map a size register onto 1..MAX_SIDE
    function automatic logic [SIZE_W-1:0] side_of(logic [SIZE_W-1:0] r);
        logic [SIZE_W-1:0] s;
        if (r == '0)
            s = SIZE_W'(1);
        else if (r > SIZE_W'(MAX_SIDE))
            s = SIZE_W'(MAX_SIDE);
        else
            s = r;
        return s;
    endfunction

    // Restoring remainder, three dividend bits per call
    function automatic axis_t axis_step(axis_t a, logic [MOD_W-1:0] m);
        axis_t             r;
        logic [MOD_W-1:0]  t;
        r = a;
        for (int i = 0; i < MOD_STEP; i++)
        begin
            t     = {r.rem, r.mag[MAG_W-1]};
            r.mag = {r.mag[MAG_W-2:0], 1'b0};
            if (t >= m)
                t = t - m;
            r.rem = t[REM_W-1:0];
        end
        return r;
    endfunction

    function automatic front_t front_step(front_t f, logic [MOD_W-1:0] mx,
                                          logic [MOD_W-1:0] my);
        front_t r;
        r    = f;
        r.ax = axis_step(f.ax, mx);
        r.ay = axis_step(f.ay, my);
        return r;
    endfunction

    // Fold a position of the doubled period back onto the texture
    function automatic logic [SIDE_BITS-1:0] reflect(logic [MOD_W-1:0] r,
                                                     logic [SIZE_W-1:0] side);
        logic [MOD_W-1:0] t;
        if (r < {1'b0, side})
            t = r;
        else
            t = {side, 1'b0} - MOD_W'(1) - r;
        return t[SIDE_BITS-1:0];
    endfunction

    function automatic logic [SIDE_BITS-1:0] clamp_idx(logic signed [IDX_W:0] i,
                                                       logic [SIZE_W-1:0] side);
        logic signed [IDX_W:0] s;
        logic [SIZE_W-1:0]     top;
        logic [SIDE_BITS-1:0]  c;
        s   = $signed({{(IDX_W + 1 - SIZE_W){1'b0}}, side});
        top = side - SIZE_W'(1);
        if (i < 0)
            c = '0;
        else if (i >= s)
            c = top[SIDE_BITS-1:0];
        else
            c = i[SIDE_BITS-1:0];
        return c;
    endfunction

    // Turn remainder and sign (or, for clamp, the index) into the two neighbouring texel indices
    function automatic coord_pair_t axis_wrap(axis_t a, logic [1:0] mode,
                                              logic [SIZE_W-1:0] side,
                                              logic [MOD_W-1:0] m);
        logic [MOD_W-1:0]      r0;
        logic [MOD_W-1:0]      r1;
        logic signed [IDX_W:0] i0;
        logic signed [IDX_W:0] i1;
        coord_pair_t           p;
        r0 = (a.neg && a.rem != '0) ? m - {1'b0, a.rem} : {1'b0, a.rem};
        r1 = (r0 + MOD_W'(1) == m) ? '0 : r0 + MOD_W'(1);
        i0 = (IDX_W + 1)'(a.idx);
        i1 = i0 + (IDX_W + 1)'(1);
        case (mode)
            WRAP_REPEAT:
            begin
                p.c0 = r0[SIDE_BITS-1:0];
                p.c1 = r1[SIDE_BITS-1:0];
            end
            WRAP_MIRROR:
            begin
                p.c0 = reflect(r0, side);
                p.c1 = reflect(r1, side);
            end
            default:
            begin
                p.c0 = clamp_idx(i0, side);
                p.c1 = clamp_idx(i1, side);
            end
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/bts_req_if.sv =====
// Request channel: texel writes and sample requests.
interface bts_req_if;
    logic          valid;
    logic          ready;
    bts_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bts_rsp_if.sv =====
// Response channel: filtered four-channel samples.
interface bts_rsp_if;
    logic          valid;
    logic          ready;
    bts_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bilinear_texture_sampler_unit.sv =====
// Bilinear texture sampler: clamp/repeat/mirror addressing over a 256x256 four-channel store.
// A sample gives one item on rsp; a write gives no item.
// Throughput: one item per cycle; the whole pipeline advances together and holds on a stall.
// The per-axis remainder (six stages, three bits each) sets the depth of the front end.
// Reset clears valid bits and loads size 256, zero offsets and clamp; texel store is not cleared.
module bilinear_texture_sampler_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    bts_req_if.sink                          req,
    bts_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NS = bts_pkg::MOD_STAGES;

    // Configuration
    logic [bts_pkg::SIZE_W-1:0]           width_reg;
    logic [bts_pkg::SIZE_W-1:0]           height_reg;
    logic signed [bts_pkg::OFFS_BITS-1:0] offx_reg;
    logic signed [bts_pkg::OFFS_BITS-1:0] offy_reg;
    logic [1:0]                           wrapx_reg;
    logic [1:0]                           wrapy_reg;

    logic [bts_pkg::SIZE_W-1:0] w_side;
    logic [bts_pkg::SIZE_W-1:0] h_side;
    logic [bts_pkg::MOD_W-1:0]  mod_x;
    logic [bts_pkg::MOD_W-1:0]  mod_y;
    logic                       adv;

    // Stage 1: scaled coordinates
    logic                              s1_valid_reg;
    bts_pkg::req_t                     s1_req_reg;
    logic signed [bts_pkg::PROD_W-1:0] s1_px_reg;
    logic signed [bts_pkg::PROD_W-1:0] s1_py_reg;
    logic signed [bts_pkg::PROD_W-1:0] px_next;
    logic signed [bts_pkg::PROD_W-1:0] py_next;

    // Front stages: remainder pipeline
    logic [NS:0]      fv_reg;
    bts_pkg::front_t  fr_reg [NS+1];
    bts_pkg::front_t  fr0_next;

    // Wrap stage
    logic                          w_valid_reg;
    logic                          w_action_reg;
    logic [bts_pkg::ADDR_W-1:0]    w_waddr_reg;
    bts_pkg::pixel_t               w_wdata_reg;
    bts_pkg::coord_pair_t          w_x_reg;
    bts_pkg::coord_pair_t          w_y_reg;
    logic [bts_pkg::FRAC_BITS-1:0] w_fx_reg;
    logic [bts_pkg::FRAC_BITS-1:0] w_fy_reg;

    // Memory stage
    bts_pkg::pixel_t               mem_a [bts_pkg::TEX_DEPTH];
    bts_pkg::pixel_t               mem_b [bts_pkg::TEX_DEPTH];
    logic                          mem_we;
    logic                          m_valid_reg;
    bts_pkg::pixel_t               rd00_reg;
    bts_pkg::pixel_t               rd01_reg;
    bts_pkg::pixel_t               rd10_reg;
    bts_pkg::pixel_t               rd11_reg;
    logic [bts_pkg::FRAC_BITS-1:0] m_fx_reg;
    logic [bts_pkg::FRAC_BITS-1:0] m_fy_reg;

    // Blend stages
    logic                          h_valid_reg;
    logic [bts_pkg::HP_W-1:0]      h_p_reg [bts_pkg::CHANNELS][4];
    logic [bts_pkg::FRAC_BITS-1:0] h_fy_reg;
    logic [bts_pkg::FRAC_BITS:0]   m_ix;

    logic                          s_valid_reg;
    logic [bts_pkg::HP_W-1:0]      s_top_reg [bts_pkg::CHANNELS];
    logic [bts_pkg::HP_W-1:0]      s_bot_reg [bts_pkg::CHANNELS];
    logic [bts_pkg::FRAC_BITS-1:0] s_fy_reg;
    logic [bts_pkg::FRAC_BITS:0]   s_iy;

    logic                          q_valid_reg;
    logic [bts_pkg::ACC_W-1:0]     q_a_reg [bts_pkg::CHANNELS];
    logic [bts_pkg::ACC_W-1:0]     q_b_reg [bts_pkg::CHANNELS];

    logic                          rsp_valid_reg;
    bts_pkg::rsp_t                 rsp_data_reg;
    bts_pkg::rsp_t                 rsp_data_next;
    logic [bts_pkg::ACC_W-1:0]     acc [bts_pkg::CHANNELS];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bts_pkg::SIZE_W'(bts_pkg::MAX_SIDE);
            height_reg <= bts_pkg::SIZE_W'(bts_pkg::MAX_SIDE);
            offx_reg   <= '0;
            offy_reg   <= '0;
            wrapx_reg  <= bts_pkg::WRAP_CLAMP;
            wrapy_reg  <= bts_pkg::WRAP_CLAMP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bts_pkg::CFG_TEX_WIDTH:  width_reg  <= cfg_data;
                bts_pkg::CFG_TEX_HEIGHT: height_reg <= cfg_data;
                bts_pkg::CFG_OFFSET_X:   offx_reg   <= cfg_data[bts_pkg::OFFS_BITS-1:0];
                bts_pkg::CFG_OFFSET_Y:   offy_reg   <= cfg_data[bts_pkg::OFFS_BITS-1:0];
                bts_pkg::CFG_WRAP_X:     wrapx_reg  <= cfg_data[1:0];
                bts_pkg::CFG_WRAP_Y:     wrapy_reg  <= cfg_data[1:0];
                default:                 ;
            endcase
        end
    end

    // Effective sizes and remainder divisors
    always_comb
    begin
        w_side = bts_pkg::side_of(width_reg);
        h_side = bts_pkg::side_of(height_reg);
        mod_x  = (wrapx_reg == bts_pkg::WRAP_MIRROR) ? {w_side, 1'b0} : {1'b0, w_side};
        mod_y  = (wrapy_reg == bts_pkg::WRAP_MIRROR) ? {h_side, 1'b0} : {1'b0, h_side};
    end

    // Advance everything unless the output item is held
    assign adv       = !(rsp_valid_reg && !rsp.ready);
    assign req.ready = adv;

    // Scale u by width and (1 - v) by height
    always_comb
    begin
        px_next = bts_pkg::PROD_W'(req.data.u_coord)
                * bts_pkg::PROD_W'($signed({1'b0, w_side}));
        py_next = (bts_pkg::ONE_Q - bts_pkg::PROD_W'(req.data.v_coord))
                * bts_pkg::PROD_W'($signed({1'b0, h_side}));
    end

    // Subtract half a texel, add offset, split into index and fraction
    always_comb
    begin
        logic signed [bts_pkg::PROD_W-1:0] tx;
        logic signed [bts_pkg::PROD_W-1:0] ty;
        logic signed [bts_pkg::IDX_W-1:0]  nx;
        logic signed [bts_pkg::IDX_W-1:0]  ny;
        tx = s1_px_reg - bts_pkg::HALF_Q
           + (bts_pkg::PROD_W'(offx_reg) <<< bts_pkg::FRAC_BITS);
        ty = s1_py_reg - bts_pkg::HALF_Q
           + (bts_pkg::PROD_W'(offy_reg) <<< bts_pkg::FRAC_BITS);
        fr0_next.action  = s1_req_reg.action;
        fr0_next.waddr   = {s1_req_reg.texel_y, s1_req_reg.texel_x};
        fr0_next.wdata   = {s1_req_reg.texel_c3, s1_req_reg.texel_c2,
                            s1_req_reg.texel_c1, s1_req_reg.texel_c0};
        fr0_next.ax.idx  = $signed(tx[bts_pkg::PROD_W-1:bts_pkg::FRAC_BITS]);
        fr0_next.ax.frac = tx[bts_pkg::FRAC_BITS-1:0];
        fr0_next.ax.neg  = tx[bts_pkg::PROD_W-1];
        fr0_next.ay.idx  = $signed(ty[bts_pkg::PROD_W-1:bts_pkg::FRAC_BITS]);
        fr0_next.ay.frac = ty[bts_pkg::FRAC_BITS-1:0];
        fr0_next.ay.neg  = ty[bts_pkg::PROD_W-1];
        nx = -fr0_next.ax.idx;
        ny = -fr0_next.ay.idx;
        fr0_next.ax.mag  = fr0_next.ax.neg ? nx[bts_pkg::MAG_W-1:0]
                                           : fr0_next.ax.idx[bts_pkg::MAG_W-1:0];
        fr0_next.ay.mag  = fr0_next.ay.neg ? ny[bts_pkg::MAG_W-1:0]
                                           : fr0_next.ay.idx[bts_pkg::MAG_W-1:0];
        fr0_next.ax.rem  = '0;
        fr0_next.ay.rem  = '0;
    end

    // Valid bits of the front end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fv_reg       <= '0;
            w_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= req.valid;
            fv_reg       <= {fv_reg[NS-1:0], s1_valid_reg};
            w_valid_reg  <= fv_reg[NS];
        end
    end

    // Front-end payload: scale, split, remainder steps, wrap
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_req_reg <= req.data;
            s1_px_reg  <= px_next;
            s1_py_reg  <= py_next;
            fr_reg[0]  <= fr0_next;
            for (int k = 0; k < NS; k++)
            begin
                fr_reg[k+1] <= bts_pkg::front_step(fr_reg[k], mod_x, mod_y);
            end
            w_action_reg <= fr_reg[NS].action;
            w_waddr_reg  <= fr_reg[NS].waddr;
            w_wdata_reg  <= fr_reg[NS].wdata;
            w_x_reg      <= bts_pkg::axis_wrap(fr_reg[NS].ax, wrapx_reg, w_side, mod_x);
            w_y_reg      <= bts_pkg::axis_wrap(fr_reg[NS].ay, wrapy_reg, h_side, mod_y);
            w_fx_reg     <= fr_reg[NS].ax.frac;
            w_fy_reg     <= fr_reg[NS].ay.frac;
        end
    end

    // Texel store: two copies, two read ports each, written in item order
    assign mem_we = adv && w_valid_reg && (w_action_reg == bts_pkg::ACT_WRITE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_a[w_waddr_reg] <= w_wdata_reg;
            mem_b[w_waddr_reg] <= w_wdata_reg;
        end
        if (adv)
        begin
            rd00_reg <= mem_a[{w_y_reg.c0, w_x_reg.c0}];
            rd01_reg <= mem_a[{w_y_reg.c0, w_x_reg.c1}];
            rd10_reg <= mem_b[{w_y_reg.c1, w_x_reg.c0}];
            rd11_reg <= mem_b[{w_y_reg.c1, w_x_reg.c1}];
            m_fx_reg <= w_fx_reg;
            m_fy_reg <= w_fy_reg;
        end
    end

    // Fraction complements
    assign m_ix = bts_pkg::ONE_F - {1'b0, m_fx_reg};
    assign s_iy = bts_pkg::ONE_F - {1'b0, s_fy_reg};

    // Round and pack the result
    always_comb
    begin
        for (int c = 0; c < bts_pkg::CHANNELS; c++)
        begin
            acc[c] = q_a_reg[c] + q_b_reg[c] + bts_pkg::RND_Q;
        end
        rsp_data_next.sample_c0 = acc[0][2*bts_pkg::FRAC_BITS +: bts_pkg::TEXEL_BITS];
        rsp_data_next.sample_c1 = acc[1][2*bts_pkg::FRAC_BITS +: bts_pkg::TEXEL_BITS];
        rsp_data_next.sample_c2 = acc[2][2*bts_pkg::FRAC_BITS +: bts_pkg::TEXEL_BITS];
        rsp_data_next.sample_c3 = acc[3][2*bts_pkg::FRAC_BITS +: bts_pkg::TEXEL_BITS];
    end

    // Valid bits of the blend end; only samples go past the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            h_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg   <= w_valid_reg && (w_action_reg == bts_pkg::ACT_SAMPLE);
            h_valid_reg   <= m_valid_reg;
            s_valid_reg   <= h_valid_reg;
            q_valid_reg   <= s_valid_reg;
            rsp_valid_reg <= q_valid_reg;
        end
    end

    // Horizontal products, horizontal sums, vertical products, output
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < bts_pkg::CHANNELS; c++)
            begin
                h_p_reg[c][0] <= bts_pkg::HP_W'(rd00_reg[c]) * bts_pkg::HP_W'(m_ix);
                h_p_reg[c][1] <= bts_pkg::HP_W'(rd01_reg[c]) * bts_pkg::HP_W'(m_fx_reg);
                h_p_reg[c][2] <= bts_pkg::HP_W'(rd10_reg[c]) * bts_pkg::HP_W'(m_ix);
                h_p_reg[c][3] <= bts_pkg::HP_W'(rd11_reg[c]) * bts_pkg::HP_W'(m_fx_reg);
                s_top_reg[c]  <= h_p_reg[c][0] + h_p_reg[c][1];
                s_bot_reg[c]  <= h_p_reg[c][2] + h_p_reg[c][3];
                q_a_reg[c]    <= bts_pkg::ACC_W'(s_top_reg[c]) * bts_pkg::ACC_W'(s_iy);
                q_b_reg[c]    <= bts_pkg::ACC_W'(s_bot_reg[c]) * bts_pkg::ACC_W'(s_fy_reg);
            end
            h_fy_reg     <= m_fy_reg;
            s_fy_reg     <= h_fy_reg;
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Remainders stay below their divisor at the end of the remainder stages
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fv_reg[NS] && fr_reg[NS].action == bts_pkg::ACT_SAMPLE)
        |-> ({1'b0, fr_reg[NS].ax.rem} < mod_x) && ({1'b0, fr_reg[NS].ay.rem} < mod_y))
        else $error("remainder out of range");

    // Wrapped indices fall inside the texture
    a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (w_valid_reg && w_action_reg == bts_pkg::ACT_SAMPLE)
        |-> ({1'b0, w_x_reg.c0} < w_side) && ({1'b0, w_x_reg.c1} < w_side)
         && ({1'b0, w_y_reg.c0} < h_side) && ({1'b0, w_y_reg.c1} < h_side))
        else $error("wrapped index outside texture");

    // Samples pass the store, writes are dropped there
    a_sample_flow: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (m_valid_reg == $past(w_valid_reg && w_action_reg == bts_pkg::ACT_SAMPLE)))
        else $error("item lost or invented at texel store");

    // A held output freezes the valid bits of stage 1, the front stages, the wrap stage and the vertical products
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready)
        |=> $stable(fv_reg) && $stable(w_valid_reg) && $stable(q_valid_reg)
         && $stable(s1_valid_reg))
        else $error("pipeline moved during stall");

endmodule

// ===== tb/bts_checker.sv =====
// Scoreboard for the bilinear texture sampler: predicts each sample and compares responses.
module bts_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    bts_req_if                             req,
    bts_rsp_if                             rsp,
    input  logic                           cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             outstanding,
    output int                             samples_seen
);
    import bts_pkg::*;

    // Shadow copy of the texture, four channels packed c3..c0
    bit [63:0]          texels [0:TEX_DEPTH-1];
    logic [8:0]         width_reg;
    logic [8:0]         height_reg;
    logic signed [7:0]  shift_x;
    logic signed [7:0]  shift_y;
    logic [1:0]         mode_x;
    logic [1:0]         mode_y;
    rsp_t               filtered_q [$];

    function automatic longint side_len(logic [8:0] r);
        longint s;
        if (r == 0)
            s = 1;
        else if (r > MAX_SIDE)
            s = MAX_SIDE;
        else
            s = r;
        return s;
    endfunction

    // Fold an integer texel index back onto 0..size-1
    function automatic longint fold_index(longint i, longint size, logic [1:0] m);
        longint r;
        longint period;
        case (m)
            WRAP_REPEAT:
            begin
                r = i % size;
                if (r < 0)
                    r += size;
            end
            WRAP_MIRROR:
            begin
                period = 2 * size;
                r = i % period;
                if (r < 0)
                    r += period;
                if (r >= size)
                    r = period - 1 - r;
            end
            default:
            begin
                r = (i < 0) ? 0 : ((i >= size) ? size - 1 : i);
            end
        endcase
        return r;
    endfunction

    // Bilinear blend of the four neighbours, one rounding at the end
    function automatic rsp_t bilinear(req_t r);
        longint          w, h, tx, ty, xi, yi, x0, x1, y0, y1;
        longint unsigned fx, fy, ix, iy, top, bot, acc;
        bit [63:0]       t00, t01, t10, t11;
        logic [15:0]     ch [4];
        rsp_t            o;
        w  = side_len(width_reg);
        h  = side_len(height_reg);
        tx = longint'(r.u_coord) * w - 32768 + longint'(shift_x) * 65536;
        ty = (65536 - longint'(r.v_coord)) * h - 32768 + longint'(shift_y) * 65536;
        xi = tx >>> 16;
        yi = ty >>> 16;
        fx = tx & 64'hFFFF;
        fy = ty & 64'hFFFF;
        x0 = fold_index(xi, w, mode_x);
        x1 = fold_index(xi + 1, w, mode_x);
        y0 = fold_index(yi, h, mode_y);
        y1 = fold_index(yi + 1, h, mode_y);
        t00 = texels[y0 * MAX_SIDE + x0];
        t01 = texels[y0 * MAX_SIDE + x1];
        t10 = texels[y1 * MAX_SIDE + x0];
        t11 = texels[y1 * MAX_SIDE + x1];
        ix = 65536 - fx;
        iy = 65536 - fy;
        for (int c = 0; c < 4; c++)
        begin
            top = longint'(t00[16*c +: 16]) * ix + longint'(t01[16*c +: 16]) * fx;
            bot = longint'(t10[16*c +: 16]) * ix + longint'(t11[16*c +: 16]) * fx;
            acc = top * iy + bot * fy + (64'd1 << 31);
            ch[c] = acc[47:32];
        end
        o.sample_c0 = ch[0];
        o.sample_c1 = ch[1];
        o.sample_c2 = ch[2];
        o.sample_c3 = ch[3];
        return o;
    endfunction

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            width_reg    <= 9'd256;
            height_reg   <= 9'd256;
            shift_x      <= '0;
            shift_y      <= '0;
            mode_x       <= WRAP_CLAMP;
            mode_y       <= WRAP_CLAMP;
            filtered_q.delete();
            fail_count   = 0;
            outstanding  <= 0;
            samples_seen <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TEX_WIDTH:  width_reg  <= cfg_data;
                    CFG_TEX_HEIGHT: height_reg <= cfg_data;
                    CFG_OFFSET_X:   shift_x    <= cfg_data[7:0];
                    CFG_OFFSET_Y:   shift_y    <= cfg_data[7:0];
                    CFG_WRAP_X:     mode_x     <= cfg_data[1:0];
                    CFG_WRAP_Y:     mode_y     <= cfg_data[1:0];
                    default: ;
                endcase
            end
            // Store writes, predict samples
            if (req.valid && req.ready)
            begin
                if (req.data.action == ACT_WRITE)
                    texels[{req.data.texel_y, req.data.texel_x}] =
                        {req.data.texel_c3, req.data.texel_c2,
                         req.data.texel_c1, req.data.texel_c0};
                else
                    filtered_q.push_back(bilinear(req.data));
            end
            // Compare each response with the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                samples_seen <= samples_seen + 1;
                if (filtered_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected item, expected none, actual %h",
                             $time, rsp.data);
                end
                else
                begin
                    want = filtered_q.pop_front();
                    compare_field("sample_c0", want.sample_c0, rsp.data.sample_c0);
                    compare_field("sample_c1", want.sample_c1, rsp.data.sample_c1);
                    compare_field("sample_c2", want.sample_c2, rsp.data.sample_c2);
                    compare_field("sample_c3", want.sample_c3, rsp.data.sample_c3);
                end
            end
            outstanding <= filtered_q.size();
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Top of the texture sampler testbench: stimulus, handshake idling and verdict.
module testbench;
    import bts_pkg::*;

    localparam logic [1:0] WRAP_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;
    int                    samples_seen;
    int                    items_sent;
    bit                    quiet;
    bit                    written [0:TEX_DEPTH-1];

    bts_req_if req ();
    bts_rsp_if rsp ();

    bilinear_texture_sampler_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bts_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .samples_seen (samples_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Response side: random stall before each item, none in quiet phases
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
        end
    end

    // Give up after a generous bound
    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    function automatic int side_len(int r);
        return (r == 0) ? 1 : ((r > MAX_SIDE) ? MAX_SIDE : r);
    endfunction

    function automatic req_t random_item(logic act);
        req_t it;
        it.action   = act;
        it.texel_x  = 8'($urandom);
        it.texel_y  = 8'($urandom);
        it.texel_c0 = 16'($urandom);
        it.texel_c1 = 16'($urandom);
        it.texel_c2 = 16'($urandom);
        it.texel_c3 = 16'($urandom);
        // Half near the unit square, half anywhere
        if ($urandom_range(0, 1))
        begin
            it.u_coord = 24'($urandom);
            it.v_coord = 24'($urandom);
        end
        else
        begin
            it.u_coord = 24'($urandom_range(0, 2 * 65536) - 32768);
            it.v_coord = 24'($urandom_range(0, 2 * 65536) - 32768);
        end
        return it;
    endfunction

    // Hold the item until accepted, after an optional gap
    task automatic send(req_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= it;
        do
            @(posedge clk);
        while (!req.ready);
        items_sent++;
        if (it.action == ACT_WRITE)
            written[{it.texel_y, it.texel_x}] = 1'b1;
    endtask

    // Drain the pipeline so registers can change safely
    task automatic settle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Assert the write enable with index and data, then drop it and wait
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Configure a phase and make sure every texel it can reach is written
    task automatic setup_phase(int w, int h, int ox, int oy, logic [1:0] mx, logic [1:0] my);
        req_t it;
        settle();
        write_reg(CFG_TEX_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_TEX_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_OFFSET_X, {1'b0, 8'(ox)});
        write_reg(CFG_OFFSET_Y, {1'b0, 8'(oy)});
        write_reg(CFG_WRAP_X, CFG_DATA_W'(mx));
        write_reg(CFG_WRAP_Y, CFG_DATA_W'(my));
        quiet = ($urandom_range(0, 3) == 0);
        for (int y = 0; y < side_len(h); y++)
            for (int x = 0; x < side_len(w); x++)
                if (!written[y * MAX_SIDE + x])
                begin
                    it = random_item(ACT_WRITE);
                    it.texel_x = 8'(x);
                    it.texel_y = 8'(y);
                    send(it);
                end
    endtask

    task automatic sample_at(int u, int v);
        req_t it;
        it = random_item(ACT_SAMPLE);
        it.u_coord = 24'(u);
        it.v_coord = 24'(v);
        send(it);
    endtask

    initial
    begin
        req_t it;
        int   w, h;
        int   coords [5];
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        req.valid  = 1'b0;
        req.data   = '0;
        quiet      = 1'b0;
        items_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme texel values and coordinates, plain clamp
        setup_phase(4, 4, 0, 0, WRAP_CLAMP, WRAP_CLAMP);
        it = random_item(ACT_WRITE);
        it.texel_x = 8'd0; it.texel_y = 8'd0;
        {it.texel_c0, it.texel_c1, it.texel_c2, it.texel_c3} = '1;
        send(it);
        it.texel_x = 8'd1; it.texel_y = 8'd1;
        {it.texel_c0, it.texel_c1, it.texel_c2, it.texel_c3} = '0;
        send(it);
        // Write beyond the configured size, at the far corner
        it.texel_x = 8'd255; it.texel_y = 8'd255;
        send(it);
        coords = '{-8388608, 8388607, 0, 32768, 65536};
        for (int i = 0; i < 5; i++)
            sample_at(coords[i], coords[(i + 2) % 5]);

        // Size zero acts as one, extreme offsets, repeat
        setup_phase(0, 0, -128, 127, WRAP_REPEAT, WRAP_REPEAT);
        sample_at(-8388608, 8388607);
        sample_at(12345, -54321);
        // Widest strip, mirror across, unused wrap selector down
        setup_phase(256, 1, 127, -128, WRAP_MIRROR, WRAP_SPARE);
        sample_at(8388607, -8388608);
        sample_at(-70000, 30000);
        sample_at(40000, 20000);
        // Oversized height acts as the maximum
        setup_phase(1, 511, 5, -3, WRAP_SPARE, WRAP_MIRROR);
        sample_at(100, 8388607);
        sample_at(-100, -8388608);
        sample_at(0, 50000);

        // Random phases: small textures mostly, occasional long strip
        for (int p = 0; p < 8; p++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                if ($urandom_range(0, 1))
                begin
                    w = 256 + $urandom_range(0, 255);
                    h = $urandom_range(0, 1);
                end
                else
                begin
                    w = $urandom_range(0, 1);
                    h = 256 + $urandom_range(0, 255);
                end
            end
            else
            begin
                w = $urandom_range(1, 16);
                h = $urandom_range(1, 16);
            end
            setup_phase(w, h, $urandom_range(0, 255), $urandom_range(0, 255),
                        2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            for (int n = 0; n < 20; n++)
            begin
                it = random_item(($urandom_range(0, 3) == 0) ? ACT_WRITE : ACT_SAMPLE);
                send(it);
            end
        end

        // Drain and give the verdict
        settle();
        $display("Sent %0d items over twelve register settings; %0d samples compared.",
                 items_sent, samples_seen);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
